>>> hdl/sile_pkg.sv
`timescale 1ns / 1ps
// sile_pkg: shared types and constants of the sorted index list engine
// depends on nothing

package sile_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int COL_W    = 31;
  localparam int LVL_W    = 16;
  localparam int VAL_W    = 64;
  localparam int LIVE_W   = 8;

  localparam logic [KEY_W-1:0] KEY_TOP  = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_DEAD = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_RESET  = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_NEXT   = 3'd3,
    OP_LOWER  = 3'd4,
    OP_REWIND = 3'd5,
    OP_DELETE = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_WR_LINK,
    S_WR_PREV,
    S_FIN
  } state_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_START,
    A_READ,
    A_EVAL,
    A_WR_LINK,
    A_WR_PREV,
    A_FIN
  } action_e;

  typedef enum logic [2:0] {
    M_SCAN,
    M_INS,
    M_DEL,
    M_ITER_LINK,
    M_ITER_ENTRY
  } mode_e;

  typedef struct packed {
    logic more;
    logic wr;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> hdl/sile_ram.sv
`timescale 1ns / 1ps
// sile_ram: generic single write port ram with registered read
// depends on nothing

module sile_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sile_ctrl.sv
`timescale 1ns / 1ps
// sile_ctrl: sequencing state machine of the sorted index list engine
// depends on sile_pkg

module sile_ctrl import sile_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output action_e  act_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_START;
      S_START:   state_d = stat_i.more ? S_READ : S_FIN;
      S_READ:    state_d = S_EVAL;
      S_EVAL: begin
        if (stat_i.more) state_d = S_READ;
        else if (stat_i.wr) state_d = S_WR_LINK;
        else state_d = S_FIN;
      end
      S_WR_LINK: state_d = S_WR_PREV;
      S_WR_PREV: state_d = S_FIN;
      S_FIN:     if (!stat_i.out_busy) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_o      = A_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) act_o = A_LOAD;
      end
      S_START:   act_o = A_START;
      S_READ:    act_o = A_READ;
      S_EVAL:    act_o = A_EVAL;
      S_WR_LINK: act_o = A_WR_LINK;
      S_WR_PREV: act_o = A_WR_PREV;
      S_FIN:     if (!stat_i.out_busy) act_o = A_FIN;
      default:   act_o = A_NONE;
    endcase
  end

endmodule

>>> hdl/sile_dp.sv
`timescale 1ns / 1ps
// sile_dp: record stores, cursors, counters and result register
// depends on sile_pkg and sile_ram

module sile_dp import sile_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  action_e           act_i,
  output dp_stat_t          stat_o,
  input  logic [2:0]        in_op_i,
  input  logic [COL_W-1:0]  in_col_i,
  input  logic [LVL_W-1:0]  in_lvl_i,
  input  logic [VAL_W-1:0]  in_val_i,
  input  logic [COL_W-1:0]  in_row_i,
  input  logic              cfg_we_i,
  input  logic [COL_W-1:0]  cfg_wdata_i,
  output logic [COL_W-1:0]  row_base_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_hit_o,
  output logic [COL_W-1:0]  out_col_o,
  output logic [LVL_W-1:0]  out_lvl_o,
  output logic [VAL_W-1:0]  out_val_o,
  output logic [LIVE_W-1:0] out_live_o,
  output logic [1:0]        out_status_o
);

  // request registers
  op_e              op_q;
  logic [COL_W-1:0] col_q, row_q;
  logic [LVL_W-1:0] lvl_q;
  logic [VAL_W-1:0] val_q;

  // list state
  mode_e             mode_q, mode_d;
  logic [SLOT_W-1:0] addr_q, addr_d, prev_q, prev_d, slot_q, slot_d;
  logic [SLOT_W-1:0] walk_q, walk_d, lower_q, lower_d, head_q, head_d;
  logic [COUNT_W-1:0] used_q, used_d;
  logic [LIVE_W-1:0] live_q, live_d;
  logic [COL_W-1:0]  cur_row_q, cur_row_d, row_base_q;

  // result
  logic             res_hit_q, res_hit_d;
  logic [COL_W-1:0] res_col_q, res_col_d;
  logic [LVL_W-1:0] res_lvl_q, res_lvl_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  status_e          res_st_q, res_st_d;

  // output register
  logic              o_valid_q;
  logic              o_hit_q;
  logic [COL_W-1:0]  o_col_q;
  logic [LVL_W-1:0]  o_lvl_q;
  logic [VAL_W-1:0]  o_val_q;
  logic [LIVE_W-1:0] o_live_q;
  logic [1:0]        o_st_q;

  // memories
  logic              key_we, lvl_we, val_we, link_we;
  logic [SLOT_W-1:0] key_wa, lvl_wa, link_wa;
  logic [KEY_W-1:0]  key_wd, key_rd, rd_key;
  logic [LVL_W-1:0]  lvl_rd;
  logic [VAL_W-1:0]  val_rd;
  logic [SLOT_W-1:0] link_wd, link_rd, rd_link;
  logic              rd_en;

  logic              more, wr, ins_go, full;
  logic [KEY_W-1:0]  bound;
  logic [COUNT_W-1:0] scan_nxt;
  logic [LVL_W-1:0]  lvl_min;

  sile_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd),
    .re_i(rd_en), .raddr_i(addr_q), .rdata_o(key_rd)
  );
  sile_ram #(.WIDTH(LVL_W), .DEPTH(CAPACITY)) u_lvl_ram (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_wa), .wdata_i(lvl_q),
    .re_i(rd_en), .raddr_i(addr_q), .rdata_o(lvl_rd)
  );
  sile_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(used_q[SLOT_W-1:0]), .wdata_i(val_q),
    .re_i(rd_en), .raddr_i(addr_q), .rdata_o(val_rd)
  );
  sile_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .re_i(rd_en), .raddr_i(addr_q), .rdata_o(link_rd)
  );

  // slot 0 is the header and lives outside the rams
  assign rd_en   = (act_i == A_READ);
  assign rd_key  = (addr_q == '0) ? KEY_TOP : key_rd;
  assign rd_link = (addr_q == '0) ? head_q : link_rd;
  assign full    = (used_q == COUNT_W'(CAPACITY));
  assign bound   = {1'b0, cur_row_q} + {1'b0, row_base_q};
  assign scan_nxt = {1'b0, addr_q} + COUNT_W'(1);
  assign lvl_min = (lvl_q < lvl_rd) ? lvl_q : lvl_rd;

  always_comb begin
    mode_d    = mode_q;
    addr_d    = addr_q;
    prev_d    = prev_q;
    slot_d    = slot_q;
    walk_d    = walk_q;
    lower_d   = lower_q;
    head_d    = head_q;
    used_d    = used_q;
    live_d    = live_q;
    cur_row_d = cur_row_q;
    res_hit_d = res_hit_q;
    res_col_d = res_col_q;
    res_lvl_d = res_lvl_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    more      = 1'b0;
    wr        = 1'b0;
    ins_go    = 1'b0;
    key_we    = 1'b0;
    key_wa    = used_q[SLOT_W-1:0];
    key_wd    = {1'b0, col_q};
    lvl_we    = 1'b0;
    lvl_wa    = used_q[SLOT_W-1:0];
    val_we    = 1'b0;
    link_we   = 1'b0;
    link_wa   = slot_q;
    link_wd   = addr_q;

    if (act_i == A_START) begin
      res_hit_d = 1'b0;
      res_col_d = '0;
      res_lvl_d = '0;
      res_val_d = '0;
      res_st_d  = ST_OK;
      unique case (op_q)
        OP_RESET: begin
          cur_row_d = row_q;
          used_d    = COUNT_W'(1);
          live_d    = '0;
          walk_d    = '0;
          lower_d   = '0;
          head_d    = '0;
        end
        OP_INSERT: ins_go = 1'b1;
        OP_UPDATE: begin
          if (used_q == COUNT_W'(1)) begin
            ins_go = 1'b1;
          end else begin
            addr_d = SLOT_W'(1);
            mode_d = M_SCAN;
            more   = 1'b1;
          end
        end
        OP_NEXT: begin
          addr_d = walk_q;
          mode_d = M_ITER_LINK;
          more   = 1'b1;
        end
        OP_LOWER: begin
          addr_d = lower_q;
          mode_d = M_ITER_LINK;
          more   = 1'b1;
        end
        OP_REWIND: begin
          walk_d  = '0;
          lower_d = '0;
        end
        OP_DELETE: begin
          if (head_q == '0) begin
            res_st_d = ST_ABSENT;
          end else begin
            addr_d = head_q;
            prev_d = '0;
            mode_d = M_DEL;
            more   = 1'b1;
          end
        end
        OP_NOP: ;
        default: ;
      endcase
    end

    if (act_i == A_EVAL) begin
      unique case (mode_q)
        M_ITER_LINK: begin
          addr_d = rd_link;
          mode_d = M_ITER_ENTRY;
          more   = 1'b1;
        end
        M_ITER_ENTRY: begin
          if (rd_key < KEY_TOP && (op_q == OP_NEXT || rd_key < bound)) begin
            if (op_q == OP_NEXT) walk_d = addr_q;
            else lower_d = addr_q;
            res_hit_d = 1'b1;
            res_col_d = rd_key[COL_W-1:0];
            res_lvl_d = lvl_rd;
            res_val_d = val_rd;
          end
        end
        M_SCAN: begin
          if (rd_key == {1'b0, col_q}) begin
            lvl_we    = (lvl_q < lvl_rd);
            lvl_wa    = addr_q;
            res_hit_d = 1'b1;
            res_col_d = col_q;
            res_lvl_d = lvl_min;
            res_val_d = val_rd;
          end else if (scan_nxt >= used_q) begin
            ins_go = 1'b1;
          end else begin
            addr_d = scan_nxt[SLOT_W-1:0];
            more   = 1'b1;
          end
        end
        M_INS: begin
          if ({1'b0, col_q} > rd_key) begin
            prev_d = addr_q;
            addr_d = rd_link;
            more   = 1'b1;
          end else begin
            wr = 1'b1;
          end
        end
        M_DEL: begin
          if (rd_key == {1'b0, col_q}) begin
            res_hit_d = 1'b1;
            res_col_d = col_q;
            res_lvl_d = lvl_rd;
            res_val_d = val_rd;
            key_we    = 1'b1;
            key_wa    = addr_q;
            key_wd    = KEY_DEAD;
            live_d    = live_q - LIVE_W'(1);
            if (prev_q == '0) begin
              head_d = rd_link;
            end else begin
              link_we = 1'b1;
              link_wa = prev_q;
              link_wd = rd_link;
            end
          end else if (rd_link == '0) begin
            res_st_d = ST_ABSENT;
          end else begin
            prev_d = addr_q;
            addr_d = rd_link;
            more   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // new slot taken from the top of the store
    if (ins_go) begin
      if (full) begin
        res_st_d = ST_FULL;
        more     = 1'b0;
      end else begin
        key_we = 1'b1;
        key_wa = used_q[SLOT_W-1:0];
        key_wd = {1'b0, col_q};
        lvl_we = 1'b1;
        lvl_wa = used_q[SLOT_W-1:0];
        val_we = 1'b1;
        slot_d = used_q[SLOT_W-1:0];
        addr_d = head_q;
        prev_d = '0;
        mode_d = M_INS;
        more   = 1'b1;
      end
    end

    if (act_i == A_WR_LINK) begin
      link_we = 1'b1;
      link_wa = slot_q;
      link_wd = addr_q;
    end

    if (act_i == A_WR_PREV) begin
      if (prev_q == '0) begin
        head_d = slot_q;
      end else begin
        link_we = 1'b1;
        link_wa = prev_q;
        link_wd = slot_q;
      end
      used_d = used_q + COUNT_W'(1);
      live_d = live_q + LIVE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_SCAN;
      addr_q     <= '0;
      prev_q     <= '0;
      slot_q     <= '0;
      walk_q     <= '0;
      lower_q    <= '0;
      head_q     <= '0;
      used_q     <= COUNT_W'(1);
      live_q     <= '0;
      cur_row_q  <= '0;
      row_base_q <= '0;
      res_st_q   <= ST_OK;
      o_valid_q  <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      addr_q    <= addr_d;
      prev_q    <= prev_d;
      slot_q    <= slot_d;
      walk_q    <= walk_d;
      lower_q   <= lower_d;
      head_q    <= head_d;
      used_q    <= used_d;
      live_q    <= live_d;
      cur_row_q <= cur_row_d;
      res_st_q  <= res_st_d;
      if (cfg_we_i) row_base_q <= cfg_wdata_i;
      if (act_i == A_FIN) o_valid_q <= 1'b1;
      else if (out_ready_i) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q <= res_hit_d;
    res_col_q <= res_col_d;
    res_lvl_q <= res_lvl_d;
    res_val_q <= res_val_d;
    if (act_i == A_LOAD) begin
      op_q  <= op_e'(in_op_i);
      col_q <= in_col_i;
      lvl_q <= in_lvl_i;
      val_q <= in_val_i;
      row_q <= in_row_i;
    end
    if (act_i == A_FIN) begin
      o_hit_q  <= res_hit_q;
      o_col_q  <= res_col_q;
      o_lvl_q  <= res_lvl_q;
      o_val_q  <= res_val_q;
      o_live_q <= live_q;
      o_st_q   <= res_st_q;
    end
  end

  assign stat_o.more     = more;
  assign stat_o.wr       = wr;
  assign stat_o.out_busy = o_valid_q && !out_ready_i;

  assign row_base_o   = row_base_q;
  assign out_valid_o  = o_valid_q;
  assign out_hit_o    = o_hit_q;
  assign out_col_o    = o_col_q;
  assign out_lvl_o    = o_lvl_q;
  assign out_val_o    = o_val_q;
  assign out_live_o   = o_live_q;
  assign out_status_o = o_st_q;

endmodule

>>> hdl/sorted_index_list_engine_top.sv
`timescale 1ns / 1ps
// sorted_index_list_engine_top: stream and register ports of the engine
// depends on sile_pkg, sile_ctrl and sile_dp

// One request is worked on at a time. Insert, update and delete read one
// record and compare it in the following cycle, for every entry visited. An
// insert on a full store is dropped with a full status. An update of an
// absent key scans every used slot and then inserts. The result enters the
// output register as the engine returns to idle. A result that is not yet
// taken holds the engine in its final state. The header record sits in
// registers, so no clearing pass follows reset.

module sorted_index_list_engine_top import sile_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // s_axis_tdata: key_column, entry_level, entry_value, row_index, pad
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // op
  // m_axis_tdata: out_column, out_level, out_value, live_count, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // hit, status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  dp_stat_t          stat;
  action_e           act;
  logic              cfg_we;
  logic [COL_W-1:0]  row_base;
  logic              out_hit;
  logic [COL_W-1:0]  out_col;
  logic [LVL_W-1:0]  out_lvl;
  logic [VAL_W-1:0]  out_val;
  logic [LIVE_W-1:0] out_live;
  logic [1:0]        out_status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {1'b0, row_base};

  sile_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .act_o     (act)
  );

  sile_dp u_dp (
    .clk_i,
    .rst_ni,
    .act_i       (act),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser),
    .in_col_i    (s_axis_tdata[30:0]),
    .in_lvl_i    (s_axis_tdata[46:31]),
    .in_val_i    (s_axis_tdata[110:47]),
    .in_row_i    (s_axis_tdata[141:111]),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[30:0]),
    .row_base_o  (row_base),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_col_o   (out_col),
    .out_lvl_o   (out_lvl),
    .out_val_o   (out_val),
    .out_live_o  (out_live),
    .out_status_o(out_status)
  );

  assign m_axis_tdata = {1'b0, out_live, out_val, out_lvl, out_col};
  assign m_axis_tuser = {out_status, out_hit};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      out_col == '0 && out_lvl == '0 && out_val == '0)
    else $error("entry fields nonzero without hit");

  a_error_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> !m_axis_tuser[0])
    else $error("hit reported together with an error status");

endmodule
